// File: src/rrts_pkg.sv
// Shared constants and types of the round-robin tick scheduler.
package rrts_pkg;

	localparam int RING_DEPTH = 16;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int TIME_W     = 16;
	localparam int ID_W       = 8;
	localparam int BURST_W    = 16;
	localparam int SLICE_W    = 8;
	localparam int DROP_W     = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_W     = 2;

	localparam logic [SLICE_W-1:0] SLICE_RESET  = 8'd4;
	localparam logic [TIME_W-1:0]  CUTOFF_RESET = 16'd100;
	localparam logic [TIME_W-1:0]  TIME_MAX     = {TIME_W{1'b1}};

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam int PADDR_W = 3;
	localparam logic REG_SLICE  = 1'b0;
	localparam logic REG_CUTOFF = 1'b1;

	typedef struct packed {
		logic               func;
		logic [ID_W-1:0]    arrive_id;
		logic [BURST_W-1:0] arrive_burst;
	} item_t;

	typedef struct packed {
		logic               was_tick;
		logic               accepted;
		logic               ran_valid;
		logic [ID_W-1:0]    ran_id;
		logic               finished;
		logic [TIME_W-1:0]  start_at;
		logic [TIME_W-1:0]  tick_time;
		logic [DROP_W-1:0]  dropped_count;
		logic               all_done;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} front_out_t;

endpackage

// File: src/rrts_front.sv
// Input queue that accepts items and presents the oldest one to the engine.
module rrts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rrts_pkg::item_t     item,
	output rrts_pkg::front_out_t head,
	input  logic                take
);

	rrts_pkg::item_t                  mem_q [rrts_pkg::QUEUE_DEPTH];
	logic [rrts_pkg::QPTR_W-1:0]      wr_q;
	logic [rrts_pkg::QPTR_W-1:0]      rd_q;
	logic [rrts_pkg::QCNT_W-1:0]      cnt_q;
	logic                             do_push;
	logic                             do_pop;

	function automatic logic [rrts_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
		QCNT_ONE = {{(rrts_pkg::QCNT_W-1){1'b0}}, b};
	endfunction

	assign full       = (cnt_q == rrts_pkg::QCNT_W'(rrts_pkg::QUEUE_DEPTH));
	assign do_push    = push && !full;
	assign do_pop     = take && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_ONE(do_push) - QCNT_ONE(do_pop);
		end
	end

endmodule

// File: src/rrts_outq.sv
// Result queue that holds finished results until they are taken.
module rrts_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rrts_pkg::result_t    res_in,
	output logic                 room,
	output logic                 empty,
	input  logic                 pop,
	output rrts_pkg::result_t    res_out
);

	rrts_pkg::result_t               mem_q [rrts_pkg::QUEUE_DEPTH];
	logic [rrts_pkg::QPTR_W-1:0]     wr_q;
	logic [rrts_pkg::QPTR_W-1:0]     rd_q;
	logic [rrts_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;
	logic [rrts_pkg::QCNT_W-1:0]     inc;
	logic [rrts_pkg::QCNT_W-1:0]     dec;

	assign room    = (cnt_q != rrts_pkg::QCNT_W'(rrts_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && room;
	assign do_pop  = pop && !empty;
	assign res_out = mem_q[rd_q];
	assign inc     = {{(rrts_pkg::QCNT_W-1){1'b0}}, do_push};
	assign dec     = {{(rrts_pkg::QCNT_W-1){1'b0}}, do_pop};

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + inc - dec;
		end
	end

endmodule

// File: src/rrts_back.sv
// Scheduling engine that keeps the task ring and carries out arrivals and ticks.
module rrts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrts_pkg::front_out_t          head,
	output logic                          take,
	input  logic                          room,
	output logic                          res_push,
	output rrts_pkg::result_t             res,
	input  logic [rrts_pkg::SLICE_W-1:0]  slice_length,
	input  logic [rrts_pkg::TIME_W-1:0]   admit_cutoff
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHK, ST_REM, ST_WALK, ST_REMF, ST_RUN, ST_FIN
	} state_t;

	typedef enum logic {RET_DROP, RET_FINISH} ret_t;

	localparam int SW = rrts_pkg::SLOT_W;
	localparam int CW = rrts_pkg::CNT_W;
	localparam int TW = rrts_pkg::TIME_W;

	state_t                         state_q;
	ret_t                           ret_q;
	logic [rrts_pkg::ID_W-1:0]      id_q     [rrts_pkg::RING_DEPTH];
	logic [rrts_pkg::BURST_W-1:0]   burst_q  [rrts_pkg::RING_DEPTH];
	logic [rrts_pkg::BURST_W-1:0]   done_q   [rrts_pkg::RING_DEPTH];
	logic [TW-1:0]                  start_q  [rrts_pkg::RING_DEPTH];
	logic [SW-1:0]                  link_q   [rrts_pkg::RING_DEPTH];
	logic [rrts_pkg::RING_DEPTH-1:0] used_q;
	logic [rrts_pkg::RING_DEPTH-1:0] started_q;
	logic [SW-1:0]                  head_q;
	logic [SW-1:0]                  tail_q;
	logic [CW-1:0]                  count_q;
	logic [SW-1:0]                  cur_q;
	logic                           cv_q;
	logic [rrts_pkg::SLICE_W-1:0]   slice_q;
	logic [TW-1:0]                  now_q;
	logic [SW-1:0]                  p_q;
	logic [SW-1:0]                  after_q;
	logic                           hn_q;
	logic                           ran_valid_q;
	logic [rrts_pkg::ID_W-1:0]      ran_id_q;
	logic                           fin_q;
	logic [TW-1:0]                  start_at_q;
	logic [TW-1:0]                  tick_time_q;
	logic [rrts_pkg::DROP_W-1:0]    drop_q;

	logic [SW-1:0]                  rd_addr;
	logic [SW-1:0]                  link_rd;
	logic [SW-1:0]                  free_slot;
	logic                           go;
	logic                           arr_go;
	logic                           admit;
	logic                           new_wr;
	logic                           walk_hit;
	logic [rrts_pkg::BURST_W-1:0]   done_new;
	logic [TW-1:0]                  start_new;
	logic [TW-1:0]                  now_next;

	assign go        = (state_q == ST_IDLE) && head.valid && room;
	assign take      = go;
	assign arr_go    = go && (head.item.func == rrts_pkg::FUNC_ARRIVE);
	assign admit     = (now_q < admit_cutoff) && (count_q < CW'(rrts_pkg::RING_DEPTH));
	assign new_wr    = arr_go && admit;
	assign rd_addr   = (state_q == ST_WALK) ? p_q : cur_q;
	assign link_rd   = link_q[rd_addr];
	assign walk_hit  = (state_q == ST_WALK) && (link_rd == cur_q);
	assign done_new  = (done_q[rd_addr] == '1) ? done_q[rd_addr] : done_q[rd_addr] + 1'b1;
	assign start_new = started_q[rd_addr] ? start_q[rd_addr] : now_q;
	assign now_next  = (now_q == rrts_pkg::TIME_MAX) ? now_q : now_q + 1'b1;

	always_comb begin
		free_slot = '0;
		for (int i = rrts_pkg::RING_DEPTH - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	assign res_push = arr_go || (state_q == ST_FIN);

	always_comb begin
		res               = '0;
		res.tick_time     = now_q;
		res.was_tick      = (state_q == ST_FIN);
		if (state_q == ST_FIN) begin
			res.ran_valid     = ran_valid_q;
			res.ran_id        = ran_id_q;
			res.finished      = fin_q;
			res.start_at      = start_at_q;
			res.tick_time     = tick_time_q;
			res.dropped_count = drop_q;
			res.all_done      = (now_next >= admit_cutoff) && (count_q == '0);
		end else begin
			res.accepted      = new_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (new_wr) begin
			id_q[free_slot]    <= head.item.arrive_id;
			burst_q[free_slot] <= head.item.arrive_burst;
			done_q[free_slot]  <= '0;
			start_q[free_slot] <= '0;
			link_q[free_slot]  <= '0;
			if (count_q != '0) begin
				link_q[tail_q] <= free_slot;
			end
		end
		if (walk_hit) begin
			link_q[p_q] <= after_q;
		end
		if (state_q == ST_RUN) begin
			done_q[cur_q]  <= done_new;
			start_q[cur_q] <= start_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= RET_DROP;
			used_q      <= '0;
			started_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			cv_q        <= 1'b0;
			slice_q     <= '0;
			now_q       <= '0;
			p_q         <= '0;
			after_q     <= '0;
			hn_q        <= 1'b0;
			ran_valid_q <= 1'b0;
			ran_id_q    <= '0;
			fin_q       <= 1'b0;
			start_at_q  <= '0;
			tick_time_q <= '0;
			drop_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (new_wr) begin
						used_q[free_slot]    <= 1'b1;
						started_q[free_slot] <= 1'b0;
						if (count_q == '0) begin
							head_q <= free_slot;
						end
						tail_q  <= free_slot;
						count_q <= count_q + 1'b1;
					end
					if (go && head.item.func == rrts_pkg::FUNC_TICK) begin
						ran_valid_q <= 1'b0;
						ran_id_q    <= '0;
						fin_q       <= 1'b0;
						start_at_q  <= '0;
						tick_time_q <= now_q;
						drop_q      <= '0;
						if (!cv_q) begin
							slice_q <= '0;
							cur_q   <= head_q;
							cv_q    <= (count_q != '0);
						end else if (slice_q == slice_length) begin
							slice_q <= '0;
							cur_q   <= (cur_q != tail_q) ? link_rd : head_q;
						end
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (cv_q && now_q >= admit_cutoff && !started_q[cur_q]) begin
						ret_q   <= RET_DROP;
						state_q <= ST_REM;
					end else if (cv_q) begin
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_REM: begin
					after_q <= link_rd;
					hn_q    <= (cur_q != tail_q);
					if (cur_q == head_q) begin
						head_q  <= link_rd;
						state_q <= ST_REMF;
					end else begin
						p_q     <= head_q;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_hit) begin
						if (cur_q == tail_q) begin
							tail_q <= p_q;
						end
						state_q <= ST_REMF;
					end else begin
						p_q <= link_rd;
					end
				end
				ST_REMF: begin
					count_q          <= count_q - 1'b1;
					used_q[cur_q]    <= 1'b0;
					started_q[cur_q] <= 1'b0;
					slice_q          <= '0;
					if (ret_q == RET_DROP) begin
						drop_q <= drop_q + 1'b1;
						if (hn_q) begin
							cur_q <= after_q;
							cv_q  <= 1'b1;
						end else begin
							cur_q <= head_q;
							cv_q  <= (count_q > CW'(1));
						end
						state_q <= ST_CHK;
					end else begin
						cur_q   <= after_q;
						cv_q    <= hn_q;
						state_q <= ST_FIN;
					end
				end
				ST_RUN: begin
					ran_valid_q      <= 1'b1;
					ran_id_q         <= id_q[rd_addr];
					slice_q          <= slice_q + 1'b1;
					started_q[cur_q] <= 1'b1;
					start_at_q       <= start_new;
					if (done_new >= burst_q[rd_addr]) begin
						fin_q   <= 1'b1;
						ret_q   <= RET_FINISH;
						state_q <= ST_REM;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					now_q   <= now_next;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/round_robin_tick_scheduler_unit.sv
// Top level of the round-robin tick scheduler with its configuration port.
// An arrival result is pushed into the result queue as the engine takes the arrival; a
// tick result passes the check and finish states, the run state when a task runs, and a
// removal per dropped or finished task that may walk the ring links to find its predecessor.
// One item is in the engine at a time; two-entry queues on both sides decouple it.
// Reset is asynchronous and active low; it empties the ring and both queues.
module round_robin_tick_scheduler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rrts_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic                           func,
	input  logic [rrts_pkg::ID_W-1:0]      arrive_id,
	input  logic [rrts_pkg::BURST_W-1:0]   arrive_burst,
	output logic                           empty,
	input  logic                           pop,
	output logic                           was_tick,
	output logic                           accepted,
	output logic                           ran_valid,
	output logic [rrts_pkg::ID_W-1:0]      ran_id,
	output logic                           finished,
	output logic [rrts_pkg::TIME_W-1:0]    start_at,
	output logic [rrts_pkg::TIME_W-1:0]    tick_time,
	output logic [rrts_pkg::DROP_W-1:0]    dropped_count,
	output logic                           all_done
);

	logic [rrts_pkg::SLICE_W-1:0] slice_q;
	logic [rrts_pkg::TIME_W-1:0]  cutoff_q;
	rrts_pkg::item_t              item;
	rrts_pkg::front_out_t         fhead;
	rrts_pkg::result_t            res_in;
	rrts_pkg::result_t            res_out;
	logic                         take;
	logic                         room;
	logic                         res_push;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q  <= rrts_pkg::SLICE_RESET;
			cutoff_q <= rrts_pkg::CUTOFF_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == rrts_pkg::REG_SLICE) begin
				slice_q <= pwdata[rrts_pkg::SLICE_W-1:0];
			end else begin
				cutoff_q <= pwdata[rrts_pkg::TIME_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == rrts_pkg::REG_CUTOFF) begin
			prdata = {{(32 - rrts_pkg::TIME_W){1'b0}}, cutoff_q};
		end else begin
			prdata = {{(32 - rrts_pkg::SLICE_W){1'b0}}, slice_q};
		end
	end

	assign item.func         = func;
	assign item.arrive_id    = arrive_id;
	assign item.arrive_burst = arrive_burst;

	rrts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.head   (fhead),
		.take   (take)
	);

	rrts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (fhead),
		.take         (take),
		.room         (room),
		.res_push     (res_push),
		.res          (res_in),
		.slice_length (slice_q),
		.admit_cutoff (cutoff_q)
	);

	rrts_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.res_in  (res_in),
		.room    (room),
		.empty   (empty),
		.pop     (pop),
		.res_out (res_out)
	);

	assign was_tick      = res_out.was_tick;
	assign accepted      = res_out.accepted;
	assign ran_valid     = res_out.ran_valid;
	assign ran_id        = res_out.ran_id;
	assign finished      = res_out.finished;
	assign start_at      = res_out.start_at;
	assign tick_time     = res_out.tick_time;
	assign dropped_count = res_out.dropped_count;
	assign all_done      = res_out.all_done;

endmodule

// File: src/rrts_checker.sv
// Port-level checks on the scheduler's results, bound to the top level.
module rrts_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         was_tick,
	input logic                         accepted,
	input logic                         ran_valid,
	input logic                         finished,
	input logic [rrts_pkg::DROP_W-1:0]  dropped_count
);

	a_arrival_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !was_tick) |-> (!ran_valid && !finished && dropped_count == '0))
		else $error("arrival result carries tick fields");

	a_tick_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && was_tick) |-> !accepted)
		else $error("tick result marked accepted");

	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && finished) |-> ran_valid)
		else $error("finished without a run");

	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (dropped_count <= rrts_pkg::DROP_W'(rrts_pkg::RING_DEPTH)))
		else $error("dropped count beyond ring depth");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

endmodule

bind round_robin_tick_scheduler_unit rrts_checker u_rrts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.was_tick      (was_tick),
	.accepted      (accepted),
	.ran_valid     (ran_valid),
	.finished      (finished),
	.dropped_count (dropped_count)
);
